@@ src/button_debounce_press_classifier_macros.svh @@
// assertion macros for the button debounce and press classifier
// used by the top level only, no other dependencies
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define BDPC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define BDPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define BDPC_ASSERT_SAME(label, ante, cons)
`define BDPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/bdpc_pkg.sv @@
// shared types, constants and register codes of the press classifier
// no dependencies
package bdpc_pkg;

	localparam int MAX_BUTTONS     = 5;
	localparam int NUM_BUTTONS_DEF = 5;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int CODE_W = 16;
	localparam int TIME_W = 32;
	localparam int BTN_W  = 3;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;

	localparam logic [CODE_W-1:0] PIN_CODE_RST [MAX_BUTTONS] = '{
		16'd1, 16'd2, 16'd4, 16'd8, 16'd16
	};
	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1500;

	typedef enum logic [IDX_W-1:0] {
		REG_PIN_CODE_A      = 3'd0,
		REG_PIN_CODE_B      = 3'd1,
		REG_PIN_CODE_C      = 3'd2,
		REG_PIN_CODE_D      = 3'd3,
		REG_PIN_CODE_E      = 3'd4,
		REG_DEBOUNCE_WINDOW = 3'd5,
		REG_LONG_PRESS      = 3'd6,
		REG_EVENTS_ENABLED  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [MAX_BUTTONS-1:0][CODE_W-1:0] pin_code;
		logic [CFG_W-1:0]                   debounce_window_ms;
		logic [CFG_W-1:0]                   long_press_ms;
		logic                               events_enabled;
	} cfg_t;

	// classified event between front and back
	typedef struct packed {
		logic [BTN_W-1:0]  btn;
		logic [TIME_W-1:0] time_ms;
	} evt_t;

	typedef struct packed {
		logic [BTN_W-1:0] button_number;
		logic             is_long_press;
	} res_t;

endpackage

@@ src/bdpc_fifo.sv @@
// small register queue, used between front and back and for results
// depends on nothing but its parameters
module bdpc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ src/bdpc_front.sv @@
// front end: matches the pin code to a button and drops unmatched events
// and all events while disabled; depends on bdpc_pkg
module bdpc_front #(
	parameter int NUM_BUTTONS = bdpc_pkg::NUM_BUTTONS_DEF
) (
	input  logic                        accept,
	input  logic [bdpc_pkg::CODE_W-1:0] pin_code,
	input  logic [bdpc_pkg::TIME_W-1:0] event_time_ms,
	input  bdpc_pkg::cfg_t              cfg,
	output logic                        evt_push,
	output bdpc_pkg::evt_t              evt
);
	import bdpc_pkg::*;

	logic             found;
	logic [BTN_W-1:0] btn;

	// lowest-numbered match wins when codes repeat
	always_comb begin
		found = 1'b0;
		btn   = '0;
		for (int k = 0; k < NUM_BUTTONS; k++) begin
			if (!found && cfg.pin_code[k] == pin_code) begin
				found = 1'b1;
				btn   = BTN_W'(k);
			end
		end
	end

	assign evt_push    = accept && found && cfg.events_enabled;
	assign evt.btn     = btn;
	assign evt.time_ms = event_time_ms;

endmodule

@@ src/bdpc_back.sv @@
// back end: debounce, held-flag toggle and long-press decision per button
// depends on bdpc_pkg
module bdpc_back #(
	parameter int NUM_BUTTONS = bdpc_pkg::NUM_BUTTONS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           evt_empty,
	input  bdpc_pkg::evt_t evt,
	output logic           evt_pop,
	input  bdpc_pkg::cfg_t cfg,
	input  logic           res_full,
	output logic           res_push,
	output bdpc_pkg::res_t res
);
	import bdpc_pkg::*;

	logic [TIME_W-1:0] last_q  [NUM_BUTTONS];
	logic [TIME_W-1:0] begin_q [NUM_BUTTONS];
	logic              held_q  [NUM_BUTTONS];

	logic [TIME_W-1:0] last_sel;
	logic [TIME_W-1:0] begin_sel;
	logic              held_sel;
	logic [TIME_W-1:0] since_last;
	logic [TIME_W-1:0] held_for;
	logic              fire;
	logic              passed;

	always_comb begin
		last_sel  = '0;
		begin_sel = '0;
		held_sel  = 1'b0;
		for (int k = 0; k < NUM_BUTTONS; k++) begin
			if (evt.btn == BTN_W'(k)) begin
				last_sel  = last_q[k];
				begin_sel = begin_q[k];
				held_sel  = held_q[k];
			end
		end
	end

	// differences wrap modulo 2^32
	assign since_last = evt.time_ms - last_sel;
	assign held_for   = evt.time_ms - begin_sel;
	assign passed     = (since_last >= TIME_W'(cfg.debounce_window_ms));

	assign fire     = !evt_empty && !res_full;
	assign evt_pop  = fire;
	assign res_push = fire && passed && held_sel;

	assign res.button_number = evt.btn;
	assign res.is_long_press = (held_for > TIME_W'(cfg.long_press_ms));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_BUTTONS; k++) begin
				last_q[k]  <= '0;
				begin_q[k] <= '0;
				held_q[k]  <= 1'b0;
			end
		end else if (fire && passed) begin
			for (int k = 0; k < NUM_BUTTONS; k++) begin
				if (evt.btn == BTN_W'(k)) begin
					last_q[k] <= evt.time_ms;
					held_q[k] <= !held_q[k];
					if (!held_q[k]) begin
						begin_q[k] <= evt.time_ms;
					end
				end
			end
		end
	end

endmodule

@@ src/button_debounce_press_classifier.sv @@
// button debounce and press classifier, top level: config registers, front, back, queues
// a release passes the event queue and then the result queue on its way to the result ports
// throughput: one event per cycle while the result queue has room
// results queue two deep; a stalled consumer backs up the event queue, then full rises
// reset: asynchronous, all buttons released, times zero, config at reset values
// depends on bdpc_pkg, bdpc_fifo, bdpc_front, bdpc_back and the macros header
module button_debounce_press_classifier #(
	parameter int NUM_BUTTONS = bdpc_pkg::NUM_BUTTONS_DEF,
	parameter int QUEUE_DEPTH = bdpc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// event side
	input  logic                        push,
	output logic                        full,
	input  logic [bdpc_pkg::CODE_W-1:0] pin_code,
	input  logic [bdpc_pkg::TIME_W-1:0] event_time_ms,
	// result side
	output logic                        empty,
	input  logic                        pop,
	output logic [bdpc_pkg::BTN_W-1:0]  button_number,
	output logic                        is_long_press,
	// configuration writes
	input  logic                        cfg_write,
	input  logic [bdpc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [bdpc_pkg::CFG_W-1:0]  cfg_data
);
	import bdpc_pkg::*;

	`include "button_debounce_press_classifier_macros.svh"

	cfg_t cfg_q;

	// event queue between front and back
	logic evt_push;
	evt_t evt_in;
	logic evt_full;
	logic evt_pop;
	evt_t evt_out;
	logic evt_empty;

	// result queue towards the consumer
	logic res_push;
	res_t res_in;
	logic res_full;
	res_t res_out;

	// configuration registers: the user must write them only while the block is idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_BUTTONS; k++) begin
				cfg_q.pin_code[k] <= PIN_CODE_RST[k];
			end
			cfg_q.debounce_window_ms <= DEBOUNCE_RST;
			cfg_q.long_press_ms      <= LONG_PRESS_RST;
			cfg_q.events_enabled     <= 1'b0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PIN_CODE_A:      cfg_q.pin_code[0] <= cfg_data;
				REG_PIN_CODE_B:      cfg_q.pin_code[1] <= cfg_data;
				REG_PIN_CODE_C:      cfg_q.pin_code[2] <= cfg_data;
				REG_PIN_CODE_D:      cfg_q.pin_code[3] <= cfg_data;
				REG_PIN_CODE_E:      cfg_q.pin_code[4] <= cfg_data;
				REG_DEBOUNCE_WINDOW: cfg_q.debounce_window_ms <= cfg_data;
				REG_LONG_PRESS:      cfg_q.long_press_ms <= cfg_data;
				REG_EVENTS_ENABLED:  cfg_q.events_enabled <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// a transaction is taken whenever the event queue has room; unmatched events vanish here
	assign full = evt_full;

	bdpc_front #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_front (
		.accept        (push && !evt_full),
		.pin_code      (pin_code),
		.event_time_ms (event_time_ms),
		.cfg           (cfg_q),
		.evt_push      (evt_push),
		.evt           (evt_in)
	);

	bdpc_fifo #(
		.WIDTH ($bits(evt_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_evt_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (evt_push),
		.wdata  (evt_in),
		.full   (evt_full),
		.pop    (evt_pop),
		.rdata  (evt_out),
		.empty  (evt_empty)
	);

	// back end takes one event a cycle as long as the result queue has room
	bdpc_back #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_empty (evt_empty),
		.evt       (evt_out),
		.evt_pop   (evt_pop),
		.cfg       (cfg_q),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	bdpc_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign button_number = res_out.button_number;
	assign is_long_press = res_out.is_long_press;

	// back end never overfills the result queue
	`BDPC_ASSERT_SAME(a_res_no_overflow, res_push, !res_full)
	// back end only consumes a queued event
	`BDPC_ASSERT_SAME(a_evt_pop_valid, evt_pop, !evt_empty)
	// with both queues drained no result can appear in the next cycle
	`BDPC_ASSERT_NEXT(a_no_invented_result, evt_empty && empty, empty)

endmodule

@@ test/tb_button_debounce_press_classifier.sv @@
`timescale 1ns / 1ps
// testbench for button_debounce_press_classifier: directed and random edge events
// results checked against an in-bench model of debounce and hold timing
// depends on bdpc_pkg and the block's sources
module tb_button_debounce_press_classifier;
	import bdpc_pkg::*;

	localparam int N_BTN         = 5;
	localparam int CYCLE_LIMIT   = 400000;
	// a result passes the event queue and the result queue, two entries each
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS   = 160;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              push          = 1'b0;
	logic              full;
	logic [CODE_W-1:0] pin_code      = '0;
	logic [TIME_W-1:0] event_time_ms = '0;
	logic              empty;
	logic              pop           = 1'b0;
	logic [BTN_W-1:0]  button_number;
	logic              is_long_press;
	logic              cfg_write     = 1'b0;
	logic [IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_W-1:0]  cfg_data      = '0;

	// idling odds in percent for each side
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches    = 0;
	int cycle_count   = 0;

	// model copy of the configuration
	logic [CODE_W-1:0] pin_of [N_BTN];
	logic [CFG_W-1:0]  window_ms;
	logic [CFG_W-1:0]  long_ms;
	logic              enabled;

	// model copy of the per-button timing state
	logic [TIME_W-1:0] last_accept_ms [N_BTN];
	logic [TIME_W-1:0] press_start_ms [N_BTN];
	logic              held [N_BTN];

	// releases predicted but not yet popped, oldest first
	res_t releases_due [$];

	button_debounce_press_classifier #(
		.NUM_BUTTONS(N_BTN)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pin_code     (pin_code),
		.event_time_ms(event_time_ms),
		.empty        (empty),
		.pop          (pop),
		.button_number(button_number),
		.is_long_press(is_long_press),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// run-away guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_button_debounce_press_classifier NOT OK");
			$finish;
		end
	end

	function automatic void note_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0d, got %0d (cycle %0d)",
				what, want, got, cycle_count);
	endfunction

	// works out what one accepted edge event does to the model, queues any release
	function automatic void classify_edge(input logic [CODE_W-1:0] code,
			input logic [TIME_W-1:0] t);
		int                btn;
		logic [TIME_W-1:0] since;
		logic [TIME_W-1:0] window32;
		logic [TIME_W-1:0] long32;
		logic [TIME_W-1:0] held_for;
		res_t              rel;
		btn = -1;
		// scan downwards so the lowest matching button wins
		for (int k = N_BTN - 1; k >= 0; k--)
			if (pin_of[k] == code)
				btn = k;
		if (btn < 0 || !enabled)
			return;
		window32 = TIME_W'(window_ms);
		long32   = TIME_W'(long_ms);
		// modulo 2^32 distance from the last accepted edge
		since = t - last_accept_ms[btn];
		if (since < window32)
			return;
		last_accept_ms[btn] = t;
		if (!held[btn]) begin
			press_start_ms[btn] = t;
			held[btn] = 1'b1;
			return;
		end
		held[btn] = 1'b0;
		held_for = t - press_start_ms[btn];
		rel.button_number = btn[BTN_W-1:0];
		rel.is_long_press = (held_for > long32);
		releases_due.push_back(rel);
	endfunction

	// result side: random back-pressure, every popped transaction checked
	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (releases_due.size() == 0) begin
				note_mismatch("unexpected release, button", -1, button_number);
			end else begin
				want = releases_due.pop_front();
				if (button_number !== want.button_number)
					note_mismatch("button_number", want.button_number, button_number);
				if (is_long_press !== want.is_long_press)
					note_mismatch("is_long_press", want.is_long_press, is_long_press);
			end
		end
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	// one register write, only ever issued while the block is idle
	task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_DEBOUNCE_WINDOW: window_ms = data;
			REG_LONG_PRESS:      long_ms   = data;
			// only the low bit is kept
			REG_EVENTS_ENABLED:  enabled   = data[0];
			default:             pin_of[idx] = data;
		endcase
		@(posedge clk);
	endtask

	// one edge-event transaction; push is left high so back-to-back items stay seamless
	task automatic send_event(input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] t);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push          <= 1'b1;
		pin_code      <= code;
		event_time_ms <= t;
		// full as sampled at the edge decides acceptance
		do @(posedge clk); while (full);
		classify_edge(code, t);
	endtask

	// stop pushing, let every release come out, then allow for ignored events in flight
	task automatic wait_until_idle();
		push <= 1'b0;
		while (releases_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// events while disabled are dropped; bit 0 alone decides the enable
	task automatic test_disabled_events();
		write_register(REG_EVENTS_ENABLED, 16'hFFFE);
		send_event(16'd1, 32'd100);
		send_event(16'd1, 32'd300);
		wait_until_idle();
		write_register(REG_EVENTS_ENABLED, 16'h0001);
	endtask

	// last accept time starts at zero, so edges before the window are dropped
	task automatic test_early_first_event();
		send_event(16'd1, 32'd10);
		send_event(16'd1, 32'd49);
		send_event(16'd1, 32'd50);
		send_event(16'd1, 32'd80);
		send_event(16'd1, 32'd100);
	endtask

	// a hold of exactly the threshold is short, one more is long
	task automatic test_long_threshold();
		send_event(16'd2, 32'd1000);
		send_event(16'd2, 32'd2500);
		send_event(16'd2, 32'd3000);
		send_event(16'd2, 32'd4501);
	endtask

	task automatic test_unmatched_codes();
		send_event(16'hFFFF, 32'd5000);
		send_event(16'h0000, 32'd5100);
		send_event(16'h0003, 32'd5200);
	endtask

	// same code on buttons one and two: button one takes it
	task automatic test_duplicate_codes();
		wait_until_idle();
		write_register(REG_PIN_CODE_C, 16'd2);
		send_event(16'd2, 32'd6000);
		send_event(16'd2, 32'd6100);
	endtask

	// hold that spans the timestamp wrap
	task automatic test_time_wrap();
		send_event(16'd16, 32'hFFFF_FF00);
		send_event(16'd16, 32'h0000_0500);
	endtask

	// zero window and threshold, then both at their maximum with extreme pin codes
	task automatic test_extreme_settings();
		wait_until_idle();
		write_register(REG_DEBOUNCE_WINDOW, 16'd0);
		write_register(REG_LONG_PRESS, 16'd0);
		send_event(16'd8, 32'd7000);
		send_event(16'd8, 32'd7000);
		send_event(16'd8, 32'd7000);
		send_event(16'd8, 32'd7001);
		wait_until_idle();
		write_register(REG_DEBOUNCE_WINDOW, 16'hFFFF);
		write_register(REG_LONG_PRESS, 16'hFFFF);
		write_register(REG_PIN_CODE_A, 16'hFFFF);
		write_register(REG_PIN_CODE_B, 16'h0000);
		send_event(16'hFFFF, 32'd100000);
		send_event(16'hFFFF, 32'd165534);
		send_event(16'hFFFF, 32'd165535);
	endtask

	// random settings, then press/release runs with timing spread around window and threshold
	task automatic test_random_events(input int phase, input int count);
		logic [CFG_W-1:0]  win;
		logic [CFG_W-1:0]  lng;
		logic [CFG_W-1:0]  pin;
		logic [CODE_W-1:0] code;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] step;
		int                cur;
		int                dice;
		int                near;
		wait_until_idle();
		case (phase)
			1: begin
				win = 16'd0;
				lng = 16'd0;
			end
			4: begin
				win = 16'hFFFF;
				lng = 16'hFFFF;
			end
			7: begin
				win = DEBOUNCE_RST;
				lng = LONG_PRESS_RST;
			end
			default: begin
				win = CFG_W'($urandom_range(300));
				lng = CFG_W'($urandom_range(3000));
				if ($urandom_range(3) == 0)
					win = CFG_W'($urandom_range(16'hFFFF));
				if ($urandom_range(3) == 0)
					lng = CFG_W'($urandom_range(16'hFFFF));
			end
		endcase
		write_register(REG_DEBOUNCE_WINDOW, win);
		write_register(REG_LONG_PRESS, lng);
		for (int k = 0; k < N_BTN; k++) begin
			dice = $urandom_range(99);
			if (dice < 10 && k > 0)
				pin = pin_of[$urandom_range(k - 1)];
			else if (dice < 15)
				pin = 16'h0000;
			else if (dice < 20)
				pin = 16'hFFFF;
			else
				pin = CFG_W'($urandom_range(16'hFFFF));
			write_register(reg_idx_t'(k), pin);
		end
		// random upper bits, enable bit set
		write_register(REG_EVENTS_ENABLED, CFG_W'($urandom_range(16'hFFFF) | 16'h0001));
		now_ms = (phase == 2) ? 32'hFFFF_0000 : $urandom();
		cur = $urandom_range(N_BTN - 1);
		for (int i = 0; i < count; i++) begin
			// mostly stay on one button so press and release pair up
			if ($urandom_range(99) < 30)
				cur = $urandom_range(N_BTN - 1);
			if ($urandom_range(99) < 85)
				code = pin_of[cur];
			else
				code = CODE_W'($urandom_range(16'hFFFF));
			dice = $urandom_range(99);
			if (dice < 20) begin
				// contact bounce inside the window
				step = (win > 0) ? $urandom_range(win - 1) : 0;
			end else if (dice < 40) begin
				step = win + $urandom_range(3);
			end else if (dice < 70) begin
				near = int'(lng);
				near = near + int'($urandom_range(4)) - 2;
				step = (near < 0) ? 0 : near;
			end else if (dice < 90) begin
				step = $urandom_range(2 * lng + 200);
			end else begin
				step = $urandom();
			end
			now_ms = now_ms + step;
			send_event(code, now_ms);
		end
	endtask

	initial begin
		// model at its reset state
		for (int k = 0; k < N_BTN; k++) begin
			pin_of[k]         = PIN_CODE_RST[k];
			last_accept_ms[k] = '0;
			press_start_ms[k] = '0;
			held[k]           = 1'b0;
		end
		window_ms = DEBOUNCE_RST;
		long_ms   = LONG_PRESS_RST;
		enabled   = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 13;
		recv_idle_pct = 45;
		test_disabled_events();
		test_early_first_event();
		test_long_threshold();
		test_unmatched_codes();
		test_duplicate_codes();
		test_time_wrap();
		test_extreme_settings();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			// receiver-heavy idling, then sender-heavy, then flat out
			if (p == 3) begin
				send_idle_pct = 45;
				recv_idle_pct = 13;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			test_random_events(p, PHASE_ITEMS);
		end

		wait_until_idle();
		if (mismatches == 0 && releases_due.size() == 0)
			$display("tb_button_debounce_press_classifier OK");
		else
			$display("tb_button_debounce_press_classifier NOT OK");
		$finish;
	end

endmodule
